// ----- src/leas_pkg.sv -----
`default_nettype none

package leas_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_KIND         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_FILTER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS      = 3'd5;

    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_LEGACY_EN   = 3'd1;
    localparam logic [2:0] OP_EXTENDED_EN = 3'd2;
    localparam logic [2:0] OP_DISABLE     = 3'd3;
    localparam logic [2:0] OP_SCAN_REQ    = 3'd4;

    localparam logic [2:0] KIND_ADV_IND         = 3'd0;
    localparam logic [2:0] KIND_ADV_DIRECT_IND  = 3'd1;
    localparam logic [2:0] KIND_SCAN_RESPONSE   = 3'd4;

    localparam logic [1:0] RK_ADVERTISEMENT = 2'd0;
    localparam logic [1:0] RK_ADV_TIMEOUT   = 2'd1;
    localparam logic [1:0] RK_SET_TERM      = 2'd2;
    localparam logic [1:0] RK_SCAN_RESPONSE = 2'd3;

    localparam logic [1:0] FILTER_ACCEPT_ALL = 2'd0;
    localparam logic [1:0] FILTER_INITIATOR  = 2'd1;
    localparam logic [1:0] FILTER_LIST_ONLY  = 2'd2;

    localparam logic [19:0] DIRECTED_DEFAULT_MS = 20'd10000;
    localparam logic [7:0]  COUNT_MAX           = 8'd255;

    typedef struct packed {
        logic [47:0] own_address;
        logic [1:0]  own_address_type;
        logic [47:0] remote_address;
        logic [2:0]  adv_kind;
        logic [1:0]  scan_filter;
        logic [31:0] interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [7:0]  set_handle;
        logic [19:0] duration_ms;
        logic [47:0] scanned_address;
        logic [47:0] scanner_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [47:0] source_address;
        logic [47:0] target_address;
        logic [1:0]  source_address_type;
        logic [2:0]  packet_kind;
        logic [7:0]  term_handle;
        logic [7:0]  event_count;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/leas_in_if.sv -----
`default_nettype none

interface leas_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] now_ms;
    logic [7:0]  set_handle;
    logic [19:0] duration_ms;
    logic [47:0] scanned_address;
    logic [47:0] scanner_address;

    modport source (
        output valid, operation, now_ms, set_handle, duration_ms,
               scanned_address, scanner_address,
        input  ready
    );

    modport sink (
        input  valid, operation, now_ms, set_handle, duration_ms,
               scanned_address, scanner_address,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/leas_out_if.sv -----
`default_nettype none

interface leas_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [47:0] source_address;
    logic [47:0] target_address;
    logic [1:0]  source_address_type;
    logic [2:0]  packet_kind;
    logic [7:0]  term_handle;
    logic [7:0]  event_count;

    modport source (
        output valid, result_kind, source_address, target_address,
               source_address_type, packet_kind, term_handle, event_count,
        input  ready
    );

    modport sink (
        input  valid, result_kind, source_address, target_address,
               source_address_type, packet_kind, term_handle, event_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/le_advertiser_scheduler.sv -----
// One BLE advertiser. Operations (tick, legacy or extended enable, disable,
// scan request) enter on i_in, one beat per cycle at full rate; each beat is
// registered, decided combinationally against the advertiser state and the
// configuration, and any result (advertisement, advertising timeout, set
// terminated, scan response) lands in an output register, so a result is
// offered on o_out from the cycle after its beat leaves the input register.
// The rate holds while o_out is taken; while a result waits on o_out one more
// beat can enter the input register, after which i_in.ready stays low until
// the result is taken. Configuration is written via i_cfg_we/i_cfg_index/
// i_cfg_data; the user must do so while no beat is in flight (not enforced).
`default_nettype none

module le_advertiser_scheduler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [leas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [leas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    leas_in_if.sink                              i_in,
    leas_out_if.source                           o_out
);
    import leas_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    logic      w_fire;
    logic      w_accept;
    logic      w_res_valid;
    t_out_item w_res;

    leas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    leas_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (r_in),
        .i_fire      (w_fire),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_fire   = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.operation       <= i_in.operation;
            r_in.now_ms          <= i_in.now_ms;
            r_in.set_handle      <= i_in.set_handle;
            r_in.duration_ms     <= i_in.duration_ms;
            r_in.scanned_address <= i_in.scanned_address;
            r_in.scanner_address <= i_in.scanner_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.result_kind         = r_out.result_kind;
    assign o_out.source_address      = r_out.source_address;
    assign o_out.target_address      = r_out.target_address;
    assign o_out.source_address_type = r_out.source_address_type;
    assign o_out.packet_kind         = r_out.packet_kind;
    assign o_out.term_handle         = r_out.term_handle;
    assign o_out.event_count         = r_out.event_count;

endmodule

`default_nettype wire

// ----- src/leas_cfg.sv -----
`default_nettype none

module leas_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [leas_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [leas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output leas_pkg::t_cfg                      o_cfg
);
    import leas_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_ADDRESS:      r_cfg.own_address      <= i_cfg_data[47:0];
                CFG_OWN_ADDRESS_TYPE: r_cfg.own_address_type <= i_cfg_data[1:0];
                CFG_REMOTE_ADDRESS:   r_cfg.remote_address   <= i_cfg_data[47:0];
                CFG_ADV_KIND:         r_cfg.adv_kind         <= i_cfg_data[2:0];
                CFG_SCAN_FILTER:      r_cfg.scan_filter      <= i_cfg_data[1:0];
                CFG_INTERVAL_MS:      r_cfg.interval_ms      <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/leas_core.sv -----
`default_nettype none

module leas_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire leas_pkg::t_cfg     i_cfg,
    input  wire leas_pkg::t_in_item i_item,
    input  wire logic               i_fire,
    output logic                    o_res_valid,
    output leas_pkg::t_out_item     o_res
);
    import leas_pkg::*;

    logic        r_enabled, n_enabled;
    logic        r_extended, n_extended;
    logic        r_armed, n_armed;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_handle, n_handle;
    logic [31:0] r_end_time, n_end_time;
    logic [31:0] r_last_time, n_last_time;

    logic [2:0]  w_kind;
    logic        w_directed;
    logic        w_reached;
    logic        w_interval_ok;
    logic        w_scan_ok;
    logic [19:0] w_dur;
    logic [31:0] w_since_end;
    logic [31:0] w_since_last;

    always_comb begin
        // reserved kinds advertise as ADV_IND
        w_kind = (i_cfg.adv_kind > KIND_SCAN_RESPONSE) ? KIND_ADV_IND : i_cfg.adv_kind;
        w_directed = (w_kind == KIND_ADV_DIRECT_IND) || (w_kind == KIND_SCAN_RESPONSE);
        w_since_end = i_item.now_ms - r_end_time;
        w_since_last = i_item.now_ms - r_last_time;
        w_reached = !w_since_end[31];
        w_interval_ok = w_since_last >= i_cfg.interval_ms;
        w_dur = (i_item.duration_ms == '0 && w_directed) ? DIRECTED_DEFAULT_MS
                                                           : i_item.duration_ms;
        w_scan_ok = r_enabled && (i_item.scanned_address == i_cfg.own_address)
                    && (i_cfg.scan_filter == FILTER_ACCEPT_ALL
                        || (i_cfg.scan_filter == FILTER_INITIATOR
                            && i_item.scanner_address == i_cfg.remote_address));
    end

    always_comb begin
        n_enabled   = r_enabled;
        n_extended  = r_extended;
        n_armed     = r_armed;
        n_count     = r_count;
        n_handle    = r_handle;
        n_end_time  = r_end_time;
        n_last_time = r_last_time;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (i_item.operation)
            OP_TICK: begin
                if (r_enabled) begin
                    if (w_directed && (!r_armed || w_reached)) begin
                        n_enabled = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.result_kind = RK_ADV_TIMEOUT;
                    end else if (r_extended && r_armed && w_reached) begin
                        n_enabled = 1'b0;
                        o_res_valid = 1'b1;
                        o_res.result_kind = RK_SET_TERM;
                        o_res.term_handle = r_handle;
                        o_res.event_count = r_count;
                    end else if (w_interval_ok) begin
                        n_last_time = i_item.now_ms;
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 8'd1;
                        end
                        o_res_valid = 1'b1;
                        o_res.result_kind = RK_ADVERTISEMENT;
                        o_res.source_address = i_cfg.own_address;
                        o_res.target_address = i_cfg.remote_address;
                        o_res.source_address_type = i_cfg.own_address_type;
                        o_res.packet_kind = w_kind;
                    end
                end
            end
            OP_LEGACY_EN, OP_EXTENDED_EN: begin
                // a tick at the enable time advertises, but a directed legacy one times out
                n_enabled   = 1'b1;
                n_count     = '0;
                n_last_time = i_item.now_ms - i_cfg.interval_ms;
                n_end_time  = i_item.now_ms - i_cfg.interval_ms;
                if (i_item.operation == OP_LEGACY_EN) begin
                    n_extended = 1'b0;
                    n_armed    = 1'b0;
                end else begin
                    n_extended = 1'b1;
                    n_handle   = i_item.set_handle;
                    n_armed    = (w_dur != '0);
                    if (w_dur != '0) begin
                        n_end_time = i_item.now_ms + {12'd0, w_dur};
                    end
                end
            end
            OP_DISABLE: begin
                n_enabled = 1'b0;
            end
            OP_SCAN_REQ: begin
                if (w_scan_ok) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = RK_SCAN_RESPONSE;
                    o_res.source_address = i_cfg.own_address;
                    o_res.target_address = i_cfg.remote_address;
                    o_res.source_address_type = i_cfg.own_address_type;
                    o_res.packet_kind = KIND_SCAN_RESPONSE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_extended  <= 1'b0;
            r_armed     <= 1'b0;
            r_count     <= '0;
            r_handle    <= '0;
            r_end_time  <= '0;
            r_last_time <= '0;
        end else if (i_fire) begin
            r_enabled   <= n_enabled;
            r_extended  <= n_extended;
            r_armed     <= n_armed;
            r_count     <= n_count;
            r_handle    <= n_handle;
            r_end_time  <= n_end_time;
            r_last_time <= n_last_time;
        end
    end

    // a timeout or set-terminated report always leaves the advertiser off
    a_timeout_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && (o_res.result_kind == RK_ADV_TIMEOUT
                                  || o_res.result_kind == RK_SET_TERM)
        |=> !r_enabled)
        else $error("advertiser still enabled after timeout");

    // count only moves up on a tick, and never wraps
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.operation == OP_TICK |=> r_count >= $past(r_count))
        else $error("event count went down on a tick");

    // results come only from an enabled advertiser
    a_result_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_enabled)
        else $error("result while disabled");

    // an advertisement stamps the last event time
    a_adv_stamps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && o_res.result_kind == RK_ADVERTISEMENT
        |=> r_last_time == $past(i_item.now_ms))
        else $error("last event time not updated");

endmodule

`default_nettype wire

// ----- tb/adv_scoreboard_pkg.sv -----
package adv_scoreboard_pkg;
    import leas_pkg::*;

    localparam logic [2:0] OP_RESERVED    = 3'd7;
    localparam logic [2:0] KIND_UNDEFINED = 3'd7;
    localparam logic [1:0] ADDR_PUBLIC    = 2'd0;
    localparam logic [1:0] ADDR_RANDOM    = 2'd1;
    localparam logic [1:0] ADDR_RANDOM_ID = 2'd3;

    class adv_scoreboard;
        t_cfg        cfg;
        bit          adv_on;
        bit          ext_mode;
        bit          deadline_armed;
        logic [7:0]  adv_count;
        logic [7:0]  set_handle;
        logic [31:0] end_ms;
        logic [31:0] last_adv_ms;
        t_out_item   expected_reports[$];
        int          n_err;
        int          n_beats;
        int          n_reports;
        int          kind_seen[4];

        function new();
            cfg = '0;
            adv_on = 1'b0;
            ext_mode = 1'b0;
            deadline_armed = 1'b0;
            adv_count = '0;
            set_handle = '0;
            end_ms = '0;
            last_adv_ms = '0;
            n_err = 0;
            n_beats = 0;
            n_reports = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_OWN_ADDRESS:      cfg.own_address = d;
                CFG_OWN_ADDRESS_TYPE: cfg.own_address_type = d[1:0];
                CFG_REMOTE_ADDRESS:   cfg.remote_address = d;
                CFG_ADV_KIND:         cfg.adv_kind = d[2:0];
                CFG_SCAN_FILTER:      cfg.scan_filter = d[1:0];
                CFG_INTERVAL_MS:      cfg.interval_ms = d[31:0];
                default: ;
            endcase
        endfunction

        // kinds above scan response fall back to connectable undirected
        function logic [2:0] sent_kind();
            return (cfg.adv_kind > KIND_SCAN_RESPONSE) ? KIND_ADV_IND : cfg.adv_kind;
        endfunction

        function bit is_directed();
            return sent_kind() == KIND_ADV_DIRECT_IND || sent_kind() == KIND_SCAN_RESPONSE;
        endfunction

        function void restart(logic [31:0] now);
            adv_on = 1'b1;
            adv_count = '0;
            last_adv_ms = now - cfg.interval_ms;
            end_ms = now - cfg.interval_ms;
        endfunction

        function void take_command(t_in_item it);
            t_out_item   r;
            bit          hit;
            bit          reached;
            logic [31:0] since_end;
            logic [19:0] dur;
            r = '0;
            hit = 1'b0;
            n_beats++;
            case (it.operation)
                OP_TICK: begin
                    if (adv_on) begin
                        since_end = it.now_ms - end_ms;
                        reached = !since_end[31];
                        if (is_directed() && (!deadline_armed || reached)) begin
                            adv_on = 1'b0;
                            r.result_kind = RK_ADV_TIMEOUT;
                            hit = 1'b1;
                        end else if (ext_mode && deadline_armed && reached) begin
                            adv_on = 1'b0;
                            r.result_kind = RK_SET_TERM;
                            r.term_handle = set_handle;
                            r.event_count = adv_count;
                            hit = 1'b1;
                        end else if ((it.now_ms - last_adv_ms) >= cfg.interval_ms) begin
                            last_adv_ms = it.now_ms;
                            if (adv_count != COUNT_MAX) adv_count++;
                            r.result_kind = RK_ADVERTISEMENT;
                            r.source_address = cfg.own_address;
                            r.target_address = cfg.remote_address;
                            r.source_address_type = cfg.own_address_type;
                            r.packet_kind = sent_kind();
                            hit = 1'b1;
                        end
                    end
                end
                OP_LEGACY_EN: begin
                    restart(it.now_ms);
                    ext_mode = 1'b0;
                    deadline_armed = 1'b0;
                end
                OP_EXTENDED_EN: begin
                    restart(it.now_ms);
                    ext_mode = 1'b1;
                    set_handle = it.set_handle;
                    dur = it.duration_ms;
                    if (dur == '0 && is_directed()) dur = DIRECTED_DEFAULT_MS;
                    deadline_armed = (dur != '0);
                    if (deadline_armed) end_ms = it.now_ms + 32'(dur);
                end
                OP_DISABLE: adv_on = 1'b0;
                OP_SCAN_REQ: begin
                    if (adv_on && it.scanned_address == cfg.own_address
                            && cfg.scan_filter < FILTER_LIST_ONLY
                            && (cfg.scan_filter != FILTER_INITIATOR
                                || it.scanner_address == cfg.remote_address)) begin
                        r.result_kind = RK_SCAN_RESPONSE;
                        r.source_address = cfg.own_address;
                        r.target_address = cfg.remote_address;
                        r.source_address_type = cfg.own_address_type;
                        r.packet_kind = KIND_SCAN_RESPONSE;
                        hit = 1'b1;
                    end
                end
                default: ;
            endcase
            if (hit) expected_reports.push_back(r);
        endfunction

        function void flag(string msg);
            n_err++;
            if (n_err <= 10) $display("mismatch: %s", msg);
        endfunction

        function void field_chk(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) flag($sformatf("%s expected %0h got %0h", name, want, got));
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            n_reports++;
            if (expected_reports.size() == 0) begin
                flag($sformatf("unexpected result, kind %0d source %0h", got.result_kind,
                               got.source_address));
                return;
            end
            want = expected_reports.pop_front();
            if (!$isunknown(got.result_kind)) kind_seen[got.result_kind]++;
            field_chk("result_kind", 48'(want.result_kind), 48'(got.result_kind));
            field_chk("source_address", want.source_address, got.source_address);
            field_chk("target_address", want.target_address, got.target_address);
            field_chk("source_address_type", 48'(want.source_address_type),
                      48'(got.source_address_type));
            field_chk("packet_kind", 48'(want.packet_kind), 48'(got.packet_kind));
            field_chk("term_handle", 48'(want.term_handle), 48'(got.term_handle));
            field_chk("event_count", 48'(want.event_count), 48'(got.event_count));
        endfunction
    endclass
endpackage

// ----- tb/tb_le_advertiser_scheduler.sv -----
module tb_le_advertiser_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import leas_pkg::*;
    import adv_scoreboard_pkg::*;

    localparam logic [47:0] ALL48     = 48'hFFFF_FFFF_FFFF;
    localparam int          RUN_LIMIT = 200000;
    localparam int          SETTLE    = 4;
    localparam int          HOLD_LEN  = 300;
    localparam int          SESSIONS  = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    leas_in_if  in_if ();
    leas_out_if out_if ();

    le_advertiser_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    adv_scoreboard sb = new();
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;
    int            n_settings = 0;
    int unsigned   cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls while idle_on is set, plus one long hold when asked
    initial begin : result_sink
        int n;
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                for (n = 0; n < HOLD_LEN; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.result_kind = out_if.result_kind;
            got.source_address = out_if.source_address;
            got.target_address = out_if.target_address;
            got.source_address_type = out_if.source_address_type;
            got.packet_kind = out_if.packet_kind;
            got.term_handle = out_if.term_handle;
            got.event_count = out_if.event_count;
            sb.check_report(got);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.operation = 3'($urandom_range(0, 7));
        it.now_ms = $urandom;
        it.set_handle = 8'($urandom);
        it.duration_ms = 20'($urandom);
        it.scanned_address = rand48();
        it.scanner_address = rand48();
        return it;
    endfunction

    function automatic t_in_item mk(logic [2:0] op, logic [31:0] now, logic [7:0] h,
                                    logic [19:0] d, logic [47:0] sd, logic [47:0] sr);
        t_in_item it;
        it.operation = op;
        it.now_ms = now;
        it.set_handle = h;
        it.duration_ms = d;
        it.scanned_address = sd;
        it.scanner_address = sr;
        return it;
    endfunction

    function automatic t_cfg mk_cfg(logic [47:0] own, logic [1:0] typ, logic [47:0] peer,
                                    logic [2:0] kind, logic [1:0] filt, logic [31:0] ivl);
        t_cfg c;
        c.own_address = own;
        c.own_address_type = typ;
        c.remote_address = peer;
        c.adv_kind = kind;
        c.scan_filter = filt;
        c.interval_ms = ivl;
        return c;
    endfunction

    task automatic send_beat(input t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.operation <= it.operation;
        in_if.now_ms <= it.now_ms;
        in_if.set_handle <= it.set_handle;
        in_if.duration_ms <= it.duration_ms;
        in_if.scanned_address <= it.scanned_address;
        in_if.scanner_address <= it.scanner_address;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.take_command(it);
    endtask

    // stop offering, let every expected result arrive, then let the pipe empty
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic configure(input t_cfg c);
        write_reg(CFG_OWN_ADDRESS, c.own_address);
        write_reg(CFG_OWN_ADDRESS_TYPE, 48'(c.own_address_type));
        write_reg(CFG_REMOTE_ADDRESS, c.remote_address);
        write_reg(CFG_ADV_KIND, 48'(c.adv_kind));
        write_reg(CFG_SCAN_FILTER, 48'(c.scan_filter));
        write_reg(CFG_INTERVAL_MS, 48'(c.interval_ms));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [47:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return ALL48;
            default: return rand48();
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        logic [31:0] ivl;
        case ($urandom_range(0, 4))
            0: ivl = '0;
            1: ivl = $urandom_range(1, 10);
            2: ivl = $urandom_range(11, 300);
            3: ivl = $urandom;
            default: ivl = 32'hFFFF_FFFF;
        endcase
        return mk_cfg(pick_addr(), 2'($urandom_range(0, 3)), pick_addr(),
                      3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), ivl);
    endfunction

    // enable, then ticks on a mostly rising clock, scans and disables mixed in
    task automatic run_session(input int n);
        t_in_item    it;
        logic [31:0] t_ms;
        int          pick;
        int          step_max;
        step_max = (sb.cfg.interval_ms <= 300) ? int'(sb.cfg.interval_ms) * 2 + 3 : 40;
        t_ms = $urandom;
        for (int k = 0; k < n; k++) begin
            it = rand_item();
            pick = $urandom_range(0, 99);
            if (pick >= 90) t_ms = t_ms + $urandom;
            else t_ms = t_ms + $urandom_range(0, step_max);
            it.now_ms = t_ms;
            if (k == 0 || pick < 6) begin
                it.operation = $urandom_range(0, 1) ? OP_LEGACY_EN : OP_EXTENDED_EN;
                case ($urandom_range(0, 3))
                    0: it.duration_ms = '0;
                    1: it.duration_ms = 20'($urandom_range(1, step_max * 15));
                    2: it.duration_ms = 20'hFFFFF;
                    default: ;
                endcase
            end else if (pick < 60 || pick >= 90) begin
                it.operation = OP_TICK;
            end else if (pick < 80) begin
                it.operation = OP_SCAN_REQ;
                if ($urandom_range(0, 3) != 0) it.scanned_address = sb.cfg.own_address;
                if ($urandom_range(0, 2) != 0) it.scanner_address = sb.cfg.remote_address;
            end else if (pick < 84) begin
                it.operation = OP_DISABLE;
            end else if (pick < 87) begin
                it.now_ms = $urandom;
            end
            send_beat(it);
        end
    endtask

    initial begin : stimulus
        t_in_item it;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.operation <= OP_TICK;
        in_if.now_ms <= '0;
        in_if.set_handle <= '0;
        in_if.duration_ms <= '0;
        in_if.scanned_address <= '0;
        in_if.scanner_address <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // undirected legacy then extended, wrap of the ms clock, idle commands
        configure(mk_cfg(ALL48, ADDR_RANDOM_ID, '0, KIND_ADV_IND, FILTER_ACCEPT_ALL, '0));
        send_beat(mk(OP_TICK, '0, '0, '0, '0, '0));
        send_beat(mk(OP_SCAN_REQ, '0, '0, '0, ALL48, ALL48));
        send_beat(mk(OP_DISABLE, '0, '0, '0, '0, '0));
        send_beat(mk(OP_RESERVED, '0, '0, '0, '0, '0));
        send_beat(mk(OP_LEGACY_EN, 32'hFFFF_FFFF, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, '0, '0, '0, '0, '0));
        send_beat(mk(OP_SCAN_REQ, 32'd1, '0, '0, ALL48, ALL48));
        send_beat(mk(OP_SCAN_REQ, 32'd2, '0, '0, '0, ALL48));
        send_beat(mk(OP_EXTENDED_EN, 32'd100, 8'hFF, 20'hFFFFF, '0, '0));
        send_beat(mk(OP_TICK, 32'd200, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'd100 + 32'hFFFFF, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'd100 + 32'h100000, '0, '0, '0, '0));
        drain();

        // directed: legacy times out at once, extended gets the default duration
        configure(mk_cfg('0, ADDR_PUBLIC, ALL48, KIND_ADV_DIRECT_IND, FILTER_INITIATOR,
                         32'hFFFF_FFFF));
        send_beat(mk(OP_LEGACY_EN, 32'd5, '0, '0, '0, '0));
        send_beat(mk(OP_SCAN_REQ, 32'd5, '0, '0, '0, ALL48));
        send_beat(mk(OP_SCAN_REQ, 32'd5, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'd6, '0, '0, '0, '0));
        send_beat(mk(OP_EXTENDED_EN, 32'd1000, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'd10999, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'd11000, '0, '0, '0, '0));
        drain();

        // unknown kind acts undirected, zero duration never ends, list filter
        configure(mk_cfg(rand48(), ADDR_RANDOM, rand48(), KIND_UNDEFINED, FILTER_LIST_ONLY,
                         32'd3));
        send_beat(mk(OP_EXTENDED_EN, '0, 8'hA5, '0, '0, '0));
        send_beat(mk(OP_SCAN_REQ, 32'd1, '0, '0, sb.cfg.own_address, sb.cfg.remote_address));
        send_beat(mk(OP_TICK, 32'h8000_0000, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'h8000_0002, '0, '0, '0, '0));
        send_beat(mk(OP_TICK, 32'h8000_0003, '0, '0, '0, '0));
        send_beat(mk(OP_DISABLE, 32'h8000_0004, '0, '0, '0, '0));
        drain();

        for (int s = 0; s < SESSIONS; s++) begin
            if (s == 4) begin
                // count saturation while the result side holds off
                configure(mk_cfg(rand48(), 2'($urandom_range(0, 3)), rand48(), KIND_ADV_IND,
                                 FILTER_ACCEPT_ALL, '0));
                idle_on = 1'b0;
                send_beat(mk(OP_EXTENDED_EN, '0, 8'($urandom), 20'hFFFFF, '0, '0));
                hold_req = 1'b1;
                for (int k = 1; k <= 258; k++) begin
                    it = rand_item();
                    it.operation = OP_TICK;
                    it.now_ms = k * 100;
                    send_beat(it);
                end
                send_beat(mk(OP_TICK, 32'hFFFFF, '0, '0, '0, '0));
                drain();
                idle_on = 1'b1;
            end
            if (s >= SESSIONS - 3) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            configure(rand_cfg());
            run_session(45);
            drain();
        end

        $display("covered %0d beats over %0d settings, %0d results checked", sb.n_beats,
                 n_settings, sb.n_reports);
        $display("  advertisements %0d, adv timeouts %0d, set terminated %0d, scan rsp %0d",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        if (sb.n_err == 0 && sb.expected_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.n_err);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
